// ===== hw/rtl/ega_pkg.sv =====
// Shared types, widths and constants for the epsilon-greedy bandit agent.
// No dependencies; imported by epsilon_greedy_bandit_agent.
`timescale 1ns / 1ps
`default_nettype none

package ega_pkg;

  // Field widths.
  localparam int EpsW    = 17;   // epsilon_level
  localparam int ArmCntW = 5;    // arm_count
  localparam int SampleW = 16;   // uniform_sample
  localparam int RArmW   = 4;    // random_arm, chosen_arm
  localparam int ValW    = 32;   // Q16.16 reward and estimate
  localparam int CntW    = 32;   // pull count

  // Stream and config port widths.
  localparam int InTdataW  = 56;
  localparam int OutTdataW = 72;
  localparam int CfgAddrW  = 2;
  localparam int CfgDataW  = EpsW;

  // Datapath: one shared adder, magnitude of (reward - estimate) fits 33 bits.
  localparam int AluW = 35;
  localparam int DivW = 33;

  // Defaults and reset values.
  localparam int MaxArmsDefault = 16;
  localparam logic [EpsW-1:0]    EpsReset    = 17'd6554;
  localparam logic [ArmCntW-1:0] ArmCntReset = 5'd10;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_EPSILON   = 2'd0,
    CFG_ARM_COUNT = 2'd1
  } cfg_idx_e;

  function automatic logic [AluW-1:0] sext_val(input logic [ValW-1:0] v);
    sext_val = {{(AluW-ValW){v[ValW-1]}}, v};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/epsilon_greedy_bandit_agent.sv =====
// Epsilon-greedy bandit agent: sequencer, estimate/count tables, shared adder; uses ega_pkg.
// Steps: explore fetches, then responds; greedy scans the arms in use; reward fetches,
//   takes the magnitude, runs 33 restoring divide steps on the one shared adder, restores
//   the sign, adds and writes back. Words are taken one at a time; the next is taken
//   the cycle after the result enters the output register.
// Reset: async active low; clears valid bits, last arm, output register; config to defaults.
`timescale 1ns / 1ps
`default_nettype none

module epsilon_greedy_bandit_agent
  import ega_pkg::*;
#(
  parameter int MAX_ARMS = MaxArmsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration write port.
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgAddrW-1:0]  cfg_addr_i,
  input  wire logic [CfgDataW-1:0]  cfg_wdata_i,
  // Input stream.
  input  wire logic                 s_axis_tvalid_i,
  output      logic                 s_axis_tready_o,
  // tdata: uniform_sample[15:0], random_arm[19:16], reward_value[51:20], zero pad
  input  wire logic [InTdataW-1:0]  s_axis_tdata_i,
  // tuser: func[0]
  input  wire logic                 s_axis_tuser_i,
  // Output stream.
  output      logic                 m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // tdata: chosen_arm[3:0], explored[4], new_estimate[36:5], pull_count[68:37],
  //        zero pad
  output      logic [OutTdataW-1:0] m_axis_tdata_o
);

  localparam int ArmW = (MAX_ARMS > 1) ? $clog2(MAX_ARMS) : 1;
  localparam int BitW = $clog2(DivW + 1);

  typedef enum logic [2:0] {
    S_IDLE,   // wait for a word
    S_FETCH,  // table entry arrives
    S_SCAN,   // greedy scan, one arm per cycle
    S_ABS,    // take magnitude of the difference
    S_DIV,    // one quotient bit per cycle
    S_SIGN,   // restore quotient sign
    S_ADD,    // estimate + quotient, clamp, write back
    S_RESP    // hand result to the output register
  } state_e;

  // ---------------------------------------------------------------------------
  // Control and configuration state.
  // ---------------------------------------------------------------------------
  state_e               state_q;
  logic [EpsW-1:0]      eps_q;
  logic [ArmCntW-1:0]   arm_count_q;
  logic [ArmW-1:0]      last_arm_q;
  logic [MAX_ARMS-1:0]  valid_q;
  logic                 out_valid_q;
  logic [RArmW-1:0]     out_arm_q;
  logic                 out_expl_q;
  logic [ValW-1:0]      out_est_q;
  logic [CntW-1:0]      out_cnt_q;

  // Datapath registers.
  logic                 func_q;
  logic [ValW-1:0]      reward_q;
  logic [ArmW-1:0]      last_q;
  logic [ArmW-1:0]      scan_idx_q;
  logic [ArmW-1:0]      best_idx_q;
  logic [ValW-1:0]      best_est_q;
  logic [CntW-1:0]      best_cnt_q;
  logic [ValW-1:0]      est_q;
  logic [CntW-1:0]      cnt_q;
  logic [AluW-1:0]      diff_q;
  logic                 diff_neg_q;
  logic [CntW-1:0]      rem_q;
  logic [DivW-1:0]      quo_q;
  logic [BitW-1:0]      bit_q;
  logic [AluW-1:0]      q_q;
  logic [ArmW-1:0]      res_arm_q;
  logic                 res_expl_q;
  logic [ValW-1:0]      res_est_q;
  logic [CntW-1:0]      res_cnt_q;

  // Table memories and registered read port.
  logic [ValW-1:0]      est_mem [MAX_ARMS];
  logic [CntW-1:0]      cnt_mem [MAX_ARMS];
  logic [ValW-1:0]      est_rd_q;
  logic [CntW-1:0]      cnt_rd_q;
  logic                 vld_rd_q;

  // ---------------------------------------------------------------------------
  // Input decode.
  // ---------------------------------------------------------------------------
  logic [SampleW-1:0] in_sample;
  logic [RArmW-1:0]   in_rarm;
  logic [ValW-1:0]    in_reward;
  logic               in_func;
  logic               s_acc;

  assign in_sample = s_axis_tdata_i[15:0];
  assign in_rarm   = s_axis_tdata_i[19:16];
  assign in_reward = s_axis_tdata_i[51:20];
  assign in_func   = s_axis_tuser_i;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  // Highest arm index in use: zero arms count as one, clip to the table.
  logic [ArmW-1:0] last_w;
  always_comb begin
    if (arm_count_q == '0) begin
      last_w = '0;
    end else if (32'(arm_count_q) > MAX_ARMS) begin
      last_w = ArmW'(MAX_ARMS - 1);
    end else begin
      last_w = ArmW'(arm_count_q - 5'd1);
    end
  end

  logic            explore_w;
  logic [ArmW-1:0] rarm_arm;
  assign explore_w = ({1'b0, in_sample} <= eps_q);
  // Random arm past the arms in use saturates to the last one.
  assign rarm_arm  = (32'(in_rarm) > 32'(last_w)) ? last_w : ArmW'(in_rarm);

  // Entries never written read as zero.
  logic [ValW-1:0] est_rd_w;
  logic [CntW-1:0] cnt_rd_w;
  assign est_rd_w = vld_rd_q ? est_rd_q : '0;
  assign cnt_rd_w = vld_rd_q ? cnt_rd_q : '0;

  // Read address: one port shared by fetch and scan.
  logic            rd_en;
  logic [ArmW-1:0] rd_addr;
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state_q == S_IDLE) begin
      rd_en = s_acc;
      if (in_func) begin
        rd_addr = last_arm_q;
      end else if (explore_w) begin
        rd_addr = rarm_arm;
      end
    end else if (state_q == S_SCAN) begin
      rd_en   = 1'b1;
      rd_addr = scan_idx_q + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared adder: compare, difference, magnitude, divide step, sign, sum.
  // ---------------------------------------------------------------------------
  logic [AluW-1:0] alu_a;
  logic [AluW-1:0] alu_b;
  logic            alu_sub;
  logic [AluW-1:0] alu_res;

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state_q)
      S_SCAN: begin
        alu_a = sext_val(est_rd_w);
        alu_b = sext_val(best_est_q);
      end
      S_FETCH: begin
        alu_a = sext_val(reward_q);
        alu_b = sext_val(est_rd_w);
      end
      S_ABS:  alu_b = diff_q;
      S_DIV: begin
        alu_a = AluW'({rem_q, quo_q[DivW-1]});
        alu_b = AluW'(cnt_q);
      end
      S_SIGN: alu_b = AluW'(quo_q);
      S_ADD: begin
        alu_a   = sext_val(est_q);
        alu_b   = q_q;
        alu_sub = 1'b0;
      end
      default: ;
    endcase
    alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + AluW'(alu_sub);
  end

  // Scan: take the first arm, then only a strictly larger estimate.
  logic scan_take;
  logic scan_end;
  assign scan_take = (scan_idx_q == '0) ||
                     (!alu_res[AluW-1] && (alu_res != '0));
  assign scan_end  = (scan_idx_q == last_q);

  // Divide step and the clamped new estimate.
  logic [CntW:0]   div_shift;
  logic            div_ge;
  logic            sat_hi;
  logic            sat_lo;
  logic [ValW-1:0] est_new;
  assign div_shift = {rem_q, quo_q[DivW-1]};
  assign div_ge    = !alu_res[AluW-1];
  assign sat_hi    = !alu_res[AluW-1] && (alu_res[AluW-2:ValW-1] != '0);
  assign sat_lo    = alu_res[AluW-1] && (alu_res[AluW-2:ValW-1] != '1);
  assign est_new   = sat_hi ? {1'b0, {(ValW-1){1'b1}}} :
                     sat_lo ? {1'b1, {(ValW-1){1'b0}}} : alu_res[ValW-1:0];

  // ---------------------------------------------------------------------------
  // Sequencer, config registers, valid bits and output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      eps_q       <= EpsReset;
      arm_count_q <= ArmCntReset;
      last_arm_q  <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      out_arm_q   <= '0;
      out_expl_q  <= 1'b0;
      out_est_q   <= '0;
      out_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_EPSILON:   eps_q       <= cfg_wdata_i;
          CFG_ARM_COUNT: arm_count_q <= cfg_wdata_i[ArmCntW-1:0];
          default: ;
        endcase
      end

      // Load a waiting result once the output register is free; otherwise
      // drop the output word once taken.
      if ((state_q == S_RESP) && (!out_valid_q || m_axis_tready_i)) begin
        out_valid_q <= 1'b1;
        out_arm_q   <= RArmW'(res_arm_q);
        out_expl_q  <= res_expl_q;
        out_est_q   <= res_est_q;
        out_cnt_q   <= res_cnt_q;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_acc) begin
            if (in_func) begin
              state_q <= S_FETCH;
            end else if (explore_w) begin
              last_arm_q <= rarm_arm;
              state_q    <= S_FETCH;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_FETCH: state_q <= func_q ? S_ABS : S_RESP;
        S_SCAN: begin
          if (scan_end) begin
            last_arm_q <= scan_take ? scan_idx_q : best_idx_q;
            state_q    <= S_RESP;
          end
        end
        S_ABS: state_q <= S_DIV;
        S_DIV: begin
          if (bit_q == BitW'(DivW - 1)) begin
            state_q <= S_SIGN;
          end
        end
        S_SIGN: state_q <= S_ADD;
        S_ADD: begin
          valid_q[res_arm_q] <= 1'b1;
          state_q            <= S_RESP;
        end
        S_RESP: begin
          // Hold until the output register is free.
          if (!out_valid_q || m_axis_tready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          func_q     <= in_func;
          reward_q   <= in_reward;
          last_q     <= last_w;
          scan_idx_q <= '0;
          res_expl_q <= !in_func && explore_w;
          res_arm_q  <= in_func ? last_arm_q : rarm_arm;
        end
      end
      S_FETCH: begin
        if (func_q) begin
          cnt_q  <= (cnt_rd_w == '1) ? cnt_rd_w : cnt_rd_w + 1'b1;
          est_q  <= est_rd_w;
          diff_q <= alu_res;
        end else begin
          res_est_q <= est_rd_w;
          res_cnt_q <= cnt_rd_w;
        end
      end
      S_SCAN: begin
        if (scan_take) begin
          best_idx_q <= scan_idx_q;
          best_est_q <= est_rd_w;
          best_cnt_q <= cnt_rd_w;
        end
        scan_idx_q <= scan_idx_q + 1'b1;
        if (scan_end) begin
          res_arm_q <= scan_take ? scan_idx_q : best_idx_q;
          res_est_q <= scan_take ? est_rd_w : best_est_q;
          res_cnt_q <= scan_take ? cnt_rd_w : best_cnt_q;
        end
      end
      S_ABS: begin
        diff_neg_q <= diff_q[AluW-1];
        quo_q      <= diff_q[AluW-1] ? alu_res[DivW-1:0] : diff_q[DivW-1:0];
        rem_q      <= '0;
        bit_q      <= '0;
      end
      S_DIV: begin
        rem_q <= div_ge ? alu_res[CntW-1:0] : div_shift[CntW-1:0];
        quo_q <= {quo_q[DivW-2:0], div_ge};
        bit_q <= bit_q + 1'b1;
      end
      S_SIGN: q_q <= diff_neg_q ? alu_res : AluW'(quo_q);
      S_ADD: begin
        res_est_q <= est_new;
        res_cnt_q <= cnt_q;
      end
      default: ;
    endcase
  end

  // Table memories: one write in S_ADD, one registered read.
  always_ff @(posedge clk_i) begin
    if (state_q == S_ADD) begin
      est_mem[res_arm_q] <= est_new;
      cnt_mem[res_arm_q] <= cnt_q;
    end
    if (rd_en) begin
      est_rd_q <= est_mem[rd_addr];
      cnt_rd_q <= cnt_mem[rd_addr];
      vld_rd_q <= valid_q[rd_addr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_cnt_q, out_est_q, out_expl_q, out_arm_q};

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < cnt_q))
    else $error("divider remainder not below divisor");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (scan_idx_q <= last_q))
    else $error("scan index past last arm in use");

  a_update_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD) |=> ((state_q == S_RESP) && valid_q[$past(res_arm_q)]))
    else $error("updated entry not marked valid");

endmodule

`default_nettype wire
